[design/swm_pkg.sv]
package swm_pkg;

    // Field widths of the request payloads.
    localparam int IN_BITS   = 16;
    localparam int WIDTH_W   = 17;
    localparam int QUOT_BITS = 16;

    // Default build parameters.
    localparam int DEF_MAX_PAIRS_LOG2 = 20;
    localparam int DEF_SAMPLE_BITS    = 16;

    // Width of 1.0 in Q1.16.
    localparam logic [WIDTH_W-1:0] FULL_WIDTH = WIDTH_W'(65536);

    // Energy accumulator width: a run of 2^pairs_log2 full-scale squares, capped at 64 bits.
    function automatic int energy_width(input int sample_bits, input int pairs_log2);
        int w;
        w = 2 * sample_bits - 1 + pairs_log2;
        return (w > 64) ? 64 : w;
    endfunction

    // Signed cross-product accumulator width, capped at 64 bits.
    function automatic int cross_width(input int sample_bits, input int pairs_log2);
        int w;
        w = 2 * sample_bits + pairs_log2;
        return (w > 64) ? 64 : w;
    endfunction

    localparam int DEF_ROOT_W = energy_width(DEF_SAMPLE_BITS, DEF_MAX_PAIRS_LOG2);

    typedef struct packed {
        logic signed [IN_BITS-1:0] left_sample;
        logic signed [IN_BITS-1:0] right_sample;
        logic                      last_pair;
    } t_in_req;

    typedef struct packed {
        logic [WIDTH_W-1:0] width_value;
        logic               silent_channel;
        logic               run_overflow;
    } t_out_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic load;
        logic mul_step;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic silent;
        logic mag_ge_d;
    } t_dp_status;

endpackage

[design/swm_datapath.sv]
module swm_datapath #(
    parameter int MAX_PAIRS_LOG2 = swm_pkg::DEF_MAX_PAIRS_LOG2,
    parameter int SAMPLE_BITS    = swm_pkg::DEF_SAMPLE_BITS,
    parameter int EN_W           = swm_pkg::DEF_ROOT_W,
    parameter int CR_W           = swm_pkg::DEF_ROOT_W + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swm_pkg::t_dp_cmd    i_cmd,
    input  swm_pkg::t_in_req    i_in_req,
    output swm_pkg::t_dp_status o_status,
    output swm_pkg::t_out_req   o_out_req
);
    import swm_pkg::*;

    localparam int RAW_W = (SAMPLE_BITS > IN_BITS) ? SAMPLE_BITS : IN_BITS;
    localparam int PR_W  = 2 * SAMPLE_BITS;
    localparam int CNT_W = MAX_PAIRS_LOG2 + 1;
    localparam int P_W   = 2 * EN_W + 1;

    // Run accumulators.
    logic signed [CR_W-1:0]  r_cross;
    logic [EN_W-1:0]         r_left;
    logic [EN_W-1:0]         r_right;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;

    // End-of-run working registers.
    logic [EN_W-1:0]         r_md;
    logic [P_W-1:0]          r_p;
    logic [EN_W-1:0]         r_root;
    logic [EN_W:0]           r_rem;
    logic [QUOT_BITS-1:0]    r_quot;
    logic [CR_W-1:0]         r_mag;
    logic                    r_silent;
    logic                    r_ovf_run;
    logic                    r_sat;
    t_out_req                r_out;

    logic [RAW_W-1:0]        left_raw;
    logic [RAW_W-1:0]        right_raw;
    logic signed [SAMPLE_BITS-1:0] left_s;
    logic signed [SAMPLE_BITS-1:0] right_s;
    logic signed [PR_W-1:0]  cross_p;
    logic signed [PR_W-1:0]  left_sq;
    logic signed [PR_W-1:0]  right_sq;
    logic signed [CR_W:0]    cross_sum;
    logic [EN_W:0]           left_sum;
    logic [EN_W:0]           right_sum;
    logic signed [CR_W-1:0]  n_cross;
    logic [EN_W-1:0]         n_left;
    logic [EN_W-1:0]         n_right;
    logic [CR_W-1:0]         cross_mag;

    logic [EN_W:0]           mul_sum;
    logic [EN_W+2:0]         sq_rem_t;
    logic [EN_W+2:0]         sq_trial;
    logic [EN_W+2:0]         sq_diff;
    logic                    sq_ge;
    logic [EN_W:0]           dv_rem2;
    logic                    dv_ge;

    // Samples are the low SAMPLE_BITS bits of their fields, sign-extended.
    assign left_raw  = RAW_W'($unsigned(i_in_req.left_sample));
    assign right_raw = RAW_W'($unsigned(i_in_req.right_sample));
    assign left_s    = signed'(left_raw[SAMPLE_BITS-1:0]);
    assign right_s   = signed'(right_raw[SAMPLE_BITS-1:0]);

    assign cross_p  = left_s * right_s;
    assign left_sq  = left_s * left_s;
    assign right_sq = right_s * right_s;

    assign cross_sum = $signed({r_cross[CR_W-1], r_cross}) + (CR_W+1)'(cross_p);
    assign left_sum  = {1'b0, r_left} + (EN_W+1)'($unsigned(left_sq));
    assign right_sum = {1'b0, r_right} + (EN_W+1)'($unsigned(right_sq));

    // Sums saturate at the storage limits.
    always_comb begin
        if (cross_sum[CR_W] != cross_sum[CR_W-1]) begin
            n_cross = cross_sum[CR_W] ? $signed({1'b1, {(CR_W-1){1'b0}}})
                                      : $signed({1'b0, {(CR_W-1){1'b1}}});
        end else begin
            n_cross = cross_sum[CR_W-1:0];
        end
        n_left  = left_sum[EN_W]  ? {EN_W{1'b1}} : left_sum[EN_W-1:0];
        n_right = right_sum[EN_W] ? {EN_W{1'b1}} : right_sum[EN_W-1:0];
    end

    assign cross_mag = r_cross[CR_W-1] ? $unsigned(-r_cross) : $unsigned(r_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            r_cross <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (!r_count[MAX_PAIRS_LOG2]) begin
                r_cross <= n_cross;
                r_left  <= n_left;
                r_right <= n_right;
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Shift-add multiply, one multiplier bit per step, low bits first.
    assign mul_sum = r_p[P_W-1:EN_W] + (r_p[0] ? {1'b0, r_md} : '0);

    // Restoring square root, two radicand bits per step.
    assign sq_rem_t = {r_rem, r_p[2*EN_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_rem_t >= sq_trial;
    assign sq_diff  = sq_rem_t - sq_trial;

    // Restoring division, one quotient bit per step. The remainder stays below the root.
    assign dv_rem2 = {r_rem[EN_W-1:0], 1'b0};
    assign dv_ge   = dv_rem2 >= {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_md      <= r_left;
            r_p       <= P_W'(r_right);
            r_root    <= '0;
            r_rem     <= '0;
            r_mag     <= cross_mag;
            r_silent  <= o_status.silent;
            r_ovf_run <= r_ovf;
        end
        if (i_cmd.mul_step) begin
            r_p <= {1'b0, mul_sum, r_p[EN_W-1:1]};
        end
        if (i_cmd.sqrt_step) begin
            r_rem  <= sq_ge ? sq_diff[EN_W:0] : sq_rem_t[EN_W:0];
            r_root <= {r_root[EN_W-2:0], sq_ge};
            r_p    <= r_p << 2;
        end
        if (i_cmd.div_init) begin
            r_rem  <= {1'b0, r_mag[EN_W-1:0]};
            r_quot <= '0;
            r_sat  <= o_status.mag_ge_d;
        end
        if (i_cmd.div_step) begin
            r_rem  <= dv_ge ? (dv_rem2 - {1'b0, r_root}) : dv_rem2;
            r_quot <= {r_quot[QUOT_BITS-2:0], dv_ge};
        end
        if (i_cmd.out_load) begin
            if (r_silent) begin
                r_out.width_value <= FULL_WIDTH;
            end else if (r_sat) begin
                r_out.width_value <= '0;
            end else begin
                r_out.width_value <= FULL_WIDTH - {1'b0, r_quot};
            end
            r_out.silent_channel <= r_silent;
            r_out.run_overflow   <= r_ovf_run;
        end
    end

    assign o_status.silent   = (r_left == '0) || (r_right == '0);
    assign o_status.mag_ge_d = r_mag >= CR_W'(r_root);
    assign o_out_req         = r_out;

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_cross == '0) && (r_left == '0) && (r_right == '0)
                       && (r_count == '0) && !r_ovf)
        else $error("run accumulators not cleared after load");

endmodule

[design/swm_ctrl.sv]
module swm_ctrl #(
    parameter int ROOT_W = swm_pkg::DEF_ROOT_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_last_pair,
    output logic                o_in_stall,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output swm_pkg::t_dp_cmd    o_cmd,
    input  swm_pkg::t_dp_status i_status
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    typedef enum logic [6:0] {
        ST_ACC  = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_SQRT = 7'b0001000,
        ST_CMP  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_HOLD = 7'b1000000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] n_step;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_ACC);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_ACC: begin
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_last_pair) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = CNT_W'(ROOT_W - 1);
                n_state    = i_status.silent ? ST_HOLD : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_step  = CNT_W'(ROOT_W - 1);
                    n_state = ST_SQRT;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_CMP;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_CMP: begin
                o_cmd.div_init = 1'b1;
                n_step         = CNT_W'(QUOT_BITS - 1);
                n_state        = i_status.mag_ge_d ? ST_HOLD : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_HOLD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_silent_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD && i_status.silent) |=> (r_state == ST_HOLD))
        else $error("silent run did not go straight to result");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == '0) |=> (r_state == ST_HOLD))
        else $error("division did not end after the last quotient bit");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && r_state == ST_ACC))
        else $error("result load did not raise output valid");

endmodule

[design/stereo_width_meter_unit.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_in_req  (left, right, last pair)
// out      | output    | o_out_valid / i_out_stall  | o_out_req (width, silent, overflow)
//
// A sample pair is taken every cycle while a run is being accumulated.
// After the pair flagged last, the input stalls while the end-of-run unit runs a bit-serial
// multiply and square root (W steps each, where W = min(64, 2*SAMPLE_BITS - 1 + MAX_PAIRS_LOG2),
// 51 by default) and a 16-step divide. A silent run skips the multiply, root and divide;
// a correlation at or above one skips the divide.
// Reset is synchronous and active low; it clears the run and drops output valid.
// A stalled result waits in the output register; pairs of the next run are still taken,
// and only the next end-of-run waits longer for the register to free.
module stereo_width_meter_unit #(
    parameter int MAX_PAIRS_LOG2 = swm_pkg::DEF_MAX_PAIRS_LOG2,
    parameter int SAMPLE_BITS    = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  swm_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output swm_pkg::t_out_req o_out_req
);
    import swm_pkg::*;

    // Accumulator widths follow from the sample width and the longest run.
    localparam int EN_W = energy_width(SAMPLE_BITS, MAX_PAIRS_LOG2);
    localparam int CR_W = cross_width(SAMPLE_BITS, MAX_PAIRS_LOG2);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller sequences accumulation, multiply, root, divide and result load.
    swm_ctrl #(
        .ROOT_W (EN_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_pair (i_in_req.last_pair),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // The datapath holds the run sums and the shared end-of-run registers.
    swm_datapath #(
        .MAX_PAIRS_LOG2 (MAX_PAIRS_LOG2),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .EN_W           (EN_W),
        .CR_W           (CR_W)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_req  (i_in_req),
        .o_status  (status),
        .o_out_req (o_out_req)
    );

    // A shown width never exceeds 1.0.
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_req.width_value <= FULL_WIDTH))
        else $error("width above full scale");

    // A silent run always reports full width.
    a_silent_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.silent_channel) |-> (o_out_req.width_value == FULL_WIDTH))
        else $error("silent run with width below full scale");

endmodule

[tb/stereo_width_meter_unit_tb.sv]
`timescale 1ns / 1ps

module stereo_width_meter_unit_tb;
    import swm_pkg::*;

    // End-of-run latency of the default build, and the quiet time allowed after the
    // last result so that a stray extra result would still be seen.
    localparam int END_CYCLES = 2 * DEF_ROOT_W + 19;
    localparam int SETTLE_CYCLES = 4 * END_CYCLES;
    // Number of pairs a run may accumulate before further pairs are dropped.
    localparam int MAX_PAIRS = 1 << DEF_MAX_PAIRS_LOG2;

    // Content styles of the random runs.
    typedef enum int {
        STY_UNIFORM,
        STY_CORRELATED,
        STY_ANTI,
        STY_QUIET,
        STY_ONE_SILENT,
        STY_EXTREMES
    } t_run_style;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_req;

    stereo_width_meter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: the running sums of the current run, exactly as the block
    // should hold them.
    longint      acc_cross;
    logic [63:0] acc_left_en;
    logic [63:0] acc_right_en;
    int          pairs_taken;
    bit          run_overflowed;

    // Results still owed by the block, oldest first.
    t_out_req width_expect[$];
    t_out_req want_res;

    int fail_count;
    int pairs_sent;
    bit gaps_on;

    // Width from the run sums: D is the floor square root of the exact energy product,
    // the correlation is floor(|cross| * 65536 / D) capped at 1.0, and the width is its
    // complement. A correlation at or above one gives a width of zero.
    function automatic logic [WIDTH_W-1:0] width_from_sums(input longint cross_in,
                                                           input logic [63:0] left_en,
                                                           input logic [63:0] right_en);
        logic [127:0]       prod;
        logic [63:0]        root;
        logic [63:0]        trial;
        logic [63:0]        mag;
        logic [79:0]        quot;
        logic [WIDTH_W-1:0] corr;
        int                 b;
        prod = 128'(left_en) * 128'(right_en);
        root = '0;
        for (b = 63; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= prod) begin
                root = trial;
            end
        end
        mag = (cross_in < 0) ? 64'(-cross_in) : 64'(cross_in);
        if (mag >= root) begin
            corr = FULL_WIDTH;
        end else begin
            quot = (80'(mag) << QUOT_BITS) / 80'(root);
            corr = WIDTH_W'(quot);
        end
        return FULL_WIDTH - corr;
    endfunction

    // Folds one accepted request into the run sums. A last pair closes the run and
    // queues the result the block owes for it. Once the run is full, pairs are
    // dropped (the last one too) and the overflow flag sticks until the run closes.
    // With the default sizes the sums cannot reach the 64-bit limits.
    task automatic account_pair(input t_in_req req);
        longint   lv;
        longint   rv;
        t_out_req res;
        lv = $signed(req.left_sample);
        rv = $signed(req.right_sample);
        if (pairs_taken < MAX_PAIRS) begin
            acc_cross    += lv * rv;
            acc_left_en  += 64'(lv * lv);
            acc_right_en += 64'(rv * rv);
            pairs_taken++;
        end else begin
            run_overflowed = 1'b1;
        end
        if (req.last_pair) begin
            res.silent_channel = (acc_left_en == 0) || (acc_right_en == 0);
            res.width_value    = res.silent_channel ? FULL_WIDTH
                               : width_from_sums(acc_cross, acc_left_en, acc_right_en);
            res.run_overflow   = run_overflowed;
            width_expect = {width_expect, res};
            acc_cross      = 0;
            acc_left_en    = '0;
            acc_right_en   = '0;
            pairs_taken    = 0;
            run_overflowed = 1'b0;
        end
    endtask

    // Sends one request. Every call starts at the falling edge right after the
    // previous acceptance, so valid is never left high on a request already taken.
    // While valid is low the payload carries noise.
    task automatic send_pair(input int lv, input int rv, input bit last);
        t_in_req req;
        req.left_sample  = 16'(lv);
        req.right_sample = 16'(rv);
        req.last_pair    = last;
        @(negedge i_clk);
        while (gaps_on && ($urandom_range(0, 99) < 22)) begin
            i_in_valid <= 1'b0;
            i_in_req   <= t_in_req'(33'({$urandom(), $urandom()}));
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        account_pair(req);
        pairs_sent++;
    endtask

    // Drops valid and holds the sender until the block has delivered every result.
    task automatic hold_until_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (width_expect.size() != 0) @(posedge i_clk);
    endtask

    function automatic int clamp_sample(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // Mostly short runs, some medium, a few long ones.
    function automatic int pick_run_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(1, 8);
        end
        if (roll < 95) begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(41, 300);
    endfunction

    // One run of random content in one style, ending in a last pair.
    task automatic send_random_run(input int len);
        t_run_style style;
        int         shift;
        int         lv;
        int         rv;
        int         i;
        bit         mute_left;
        int         picks[5];
        picks = '{-32768, 32767, -1, 0, 1};
        style = t_run_style'($urandom_range(0, 5));
        shift = $urandom_range(0, 4);
        mute_left = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
            lv = $signed(16'($urandom));
            rv = $signed(16'($urandom));
            case (style)
                STY_CORRELATED: begin
                    rv = clamp_sample((lv >>> shift) + $urandom_range(0, 512) - 256);
                end
                STY_ANTI: begin
                    rv = clamp_sample(-(lv >>> shift) + $urandom_range(0, 512) - 256);
                end
                STY_QUIET: begin
                    lv = $urandom_range(0, 15) - 8;
                    rv = $urandom_range(0, 15) - 8;
                end
                STY_ONE_SILENT: begin
                    if (mute_left) begin
                        lv = 0;
                    end else begin
                        rv = 0;
                    end
                end
                STY_EXTREMES: begin
                    lv = picks[$urandom_range(0, 4)];
                    rv = picks[$urandom_range(0, 4)];
                end
                default: begin
                end
            endcase
            send_pair(lv, rv, i == len - 1);
        end
    endtask

    // Field extremes and the named special cases, as short hand-built runs.
    task automatic test_corner_pairs();
        // Fully correlated single pairs: the correlation reaches one, width is zero.
        send_pair(32767, 32767, 1);
        send_pair(-32768, -32768, 1);
        send_pair(-32768, 32767, 1);
        send_pair(32767, -32768, 1);
        send_pair(1, -1, 1);
        // Silence on one or both channels.
        send_pair(0, 1234, 1);
        send_pair(-5, 0, 1);
        send_pair(0, 0, 1);
        send_pair(0, -32768, 1);
        // Near-orthogonal pairs: the cross sum cancels or nearly cancels, so the width is at or near full.
        send_pair(1, 1, 0);
        send_pair(1, -1, 1);
        send_pair(32767, 32767, 0);
        send_pair(-32768, 32767, 1);
        // Partial correlation over short runs.
        send_pair(100, 50, 0);
        send_pair(-30, 200, 1);
        send_pair(20000, -3, 0);
        send_pair(-7, 31000, 0);
        send_pair(12345, 12000, 1);
        send_pair(-1, -1, 0);
        send_pair(-32768, 1, 0);
        send_pair(2, 32767, 1);
    endtask

    task automatic test_random_runs(input int count);
        int start;
        start = pairs_sent;
        while (pairs_sent - start < count) begin
            send_random_run(pick_run_len());
        end
    endtask

    // Back-to-back requests with neither side idling.
    task automatic test_idle_free_burst(input int count);
        gaps_on = 1'b0;
        test_random_runs(count);
        gaps_on = 1'b1;
    endtask

    // The next run starts only once the block has drained every result.
    task automatic test_pause_for_results(input int runs);
        int i;
        for (i = 0; i < runs; i++) begin
            send_random_run(pick_run_len());
            hold_until_results_done();
        end
    endtask

    // The receiver stalls at random while gaps are on.
    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 22);
    end

    // Each accepted result is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (width_expect.size() == 0) begin
                $error("result with none owed: width_value %0d, silent_channel %0d, run_overflow %0d",
                       o_out_req.width_value, o_out_req.silent_channel, o_out_req.run_overflow);
                fail_count++;
            end else begin
                want_res = width_expect.pop_front();
                if (o_out_req.width_value !== want_res.width_value) begin
                    $error("width_value: expected %0d, actual %0d",
                           want_res.width_value, o_out_req.width_value);
                    fail_count++;
                end
                if (o_out_req.silent_channel !== want_res.silent_channel) begin
                    $error("silent_channel: expected %0d, actual %0d",
                           want_res.silent_channel, o_out_req.silent_channel);
                    fail_count++;
                end
                if (o_out_req.run_overflow !== want_res.run_overflow) begin
                    $error("run_overflow: expected %0d, actual %0d",
                           want_res.run_overflow, o_out_req.run_overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_req       = '0;
        gaps_on        = 1'b1;
        fail_count     = 0;
        pairs_sent     = 0;
        acc_cross      = 0;
        acc_left_en    = '0;
        acc_right_en   = '0;
        pairs_taken    = 0;
        run_overflowed = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_pairs();
        test_random_runs(1100);
        test_idle_free_burst(300);
        test_pause_for_results(8);
        test_random_runs(200);

        // Wait for every owed result, then stay a while longer so that a stray
        // extra result still gets caught by the checker.
        hold_until_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stereo_width_meter_unit_tb passed");
        end else begin
            $display("stereo_width_meter_unit_tb failed");
        end
        $finish;
    end

    // Watchdog: the full run needs a small fraction of this.
    initial begin
        #100_000_000;
        $display("stereo_width_meter_unit_tb failed");
        $finish;
    end

endmodule
